// File: hw/rtl/cfe_pkg.sv
// Shared types and constants of the Cholesky factorisation engine.
package cfe_pkg;

	localparam int DATA_W   = 32;
	localparam int IDX_W    = 3;
	localparam int SIZE_W   = 4;
	localparam int OUT_TD_W = 40;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	// write data source of the matrix store
	typedef enum logic [1:0] {
		WSRC_IN   = 2'd0,
		WSRC_DIV  = 2'd1,
		WSRC_SQRT = 2'd2,
		WSRC_ZERO = 2'd3
	} wsrc_t;

	typedef struct packed {
		logic             wr_en;
		wsrc_t            wr_src;
		logic [IDX_W-1:0] wr_row;
		logic [IDX_W-1:0] wr_col;
		logic             rd_en;
		logic [IDX_W-1:0] ra_row;
		logic [IDX_W-1:0] ra_col;
		logic [IDX_W-1:0] rb_row;
		logic [IDX_W-1:0] rb_col;
		logic             acc_load;
		logic             mul_en;
		logic             acc_sub;
		logic             div_start;
		logic             sqrt_start;
		logic             out_load;
		logic             out_last;
		logic             out_fail;
	} cfe_cmd_t;

	typedef struct packed {
		logic acc_nonpos;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} cfe_stat_t;

endpackage

// File: hw/rtl/cfe_div.sv
// Restoring fixed-point divider, one quotient bit per cycle, saturating.
module cfe_div import cfe_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [63:0]       dividend,
	input  logic [DATA_W-1:0]        divisor,
	output logic                     done,
	output logic [DATA_W-1:0]        quot
);

	localparam int NW = 64 + FRAC_BITS;
	localparam int HW = NW - 33;

	logic          busy_q, done_q, ovf_q, neg_q;
	logic [5:0]    cnt_q;
	logic [31:0]   rem_q, d_q;
	logic [32:0]   num_q, q_q;
	logic [31:0]   quot_q;
	logic [63:0]   mag;
	logic [NW-1:0] num_full;
	logic [HW-1:0] hi;
	logic          ovf;
	logic [32:0]   t, diff, q_fin;
	logic          ge;
	logic [31:0]   q_sat;

	always_comb begin
		mag      = dividend[63] ? 64'(-dividend) : 64'(dividend);
		num_full = {mag, {FRAC_BITS{1'b0}}};
		hi       = num_full[NW-1:33];
		ovf      = hi >= HW'(divisor);
		t        = {rem_q, num_q[32]};
		ge       = t >= {1'b0, d_q};
		diff     = t - {1'b0, d_q};
		q_fin    = ovf_q ? '1 : q_q;
		if (neg_q)
			q_sat = (q_fin > 33'h080000000) ? 32'h80000000 : 32'(-q_fin[31:0]);
		else
			q_sat = (q_fin > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q_fin[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (ovf_q || cnt_q == 6'd0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi[31:0];
			num_q <= num_full[32:0];
			q_q   <= '0;
			cnt_q <= 6'd33;
			ovf_q <= ovf;
			neg_q <= dividend[63];
			d_q   <= divisor;
		end else if (busy_q) begin
			if (ovf_q || cnt_q == 6'd0) begin
				quot_q <= q_sat;
			end else begin
				q_q   <= {q_q[31:0], ge};
				rem_q <= ge ? diff[31:0] : t[31:0];
				num_q <= {num_q[31:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: hw/rtl/cfe_sqrt.sv
// Digit-by-digit floor square root of r * 2^FRAC_BITS, saturating.
module cfe_sqrt import cfe_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   radicand,
	output logic                 done,
	output logic [DATA_W-1:0]    root
);

	localparam logic [63:0] LIMIT = 64'(1) << (62 - FRAC_BITS);

	logic        busy_q, done_q, sat_q;
	logic [4:0]  cnt_q;
	logic [61:0] x_q;
	logic [33:0] rem_q;
	logic [30:0] res_q;
	logic [31:0] root_q;
	logic        sat;
	logic [63:0] xs;
	logic [33:0] rem2, trial;
	logic        ge;

	always_comb begin
		sat   = 64'(radicand) >= LIMIT;
		xs    = 64'(radicand) << FRAC_BITS;
		rem2  = {rem_q[31:0], x_q[61:60]};
		trial = {1'b0, res_q, 2'b01};
		ge    = rem2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (sat_q || cnt_q == 5'd0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= xs[61:0];
			rem_q <= '0;
			res_q <= '0;
			cnt_q <= 5'd31;
			sat_q <= sat;
		end else if (busy_q) begin
			if (sat_q || cnt_q == 5'd0) begin
				root_q <= sat_q ? 32'h7FFFFFFF : {1'b0, res_q};
			end else begin
				rem_q <= ge ? rem2 - trial : rem2;
				res_q <= {res_q[29:0], ge};
				x_q   <= {x_q[59:0], 2'b00};
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: hw/rtl/cfe_dpath.sv
// Datapath: matrix store, multiply-accumulate, divider, root unit, output register.
module cfe_dpath import cfe_pkg::*; #(
	parameter int MAX_N     = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfe_cmd_t          cmd,
	output cfe_stat_t         stat,
	input  logic [DATA_W-1:0] in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_value,
	output logic [IDX_W-1:0]  out_row,
	output logic [IDX_W-1:0]  out_col,
	output logic              out_fail,
	output logic              out_last
);

	localparam int DEPTH = MAX_N * MAX_N;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_a_q, rd_b_q, wr_data;
	logic [AW-1:0]     wr_addr, ra_addr, rb_addr;
	logic signed [63:0] acc_q, prod_s1;
	logic              div_done, sqrt_done;
	logic [DATA_W-1:0] div_q, sqrt_q;
	logic              out_valid_q;

	cfe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(acc_q),
		.divisor(rd_b_q), .done(div_done), .quot(div_q)
	);

	cfe_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start), .radicand(acc_q),
		.done(sqrt_done), .root(sqrt_q)
	);

	always_comb begin
		wr_addr = AW'(int'(cmd.wr_row) * MAX_N + int'(cmd.wr_col));
		ra_addr = AW'(int'(cmd.ra_row) * MAX_N + int'(cmd.ra_col));
		rb_addr = AW'(int'(cmd.rb_row) * MAX_N + int'(cmd.rb_col));
		case (cmd.wr_src)
			WSRC_IN:   wr_data = in_data;
			WSRC_DIV:  wr_data = div_q;
			WSRC_SQRT: wr_data = sqrt_q;
			default:   wr_data = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en) begin
			rd_a_q <= mem[ra_addr];
			rd_b_q <= mem[rb_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_s1 <= $signed(rd_a_q) * $signed(rd_b_q);
		if (cmd.acc_load)
			acc_q <= 64'($signed(rd_a_q));
		else if (cmd.acc_sub)
			acc_q <= acc_q - (prod_s1 >>> FRAC_BITS);
		if (cmd.out_load) begin
			out_value <= rd_a_q;
			out_row   <= cmd.ra_row;
			out_col   <= cmd.ra_col;
			out_fail  <= cmd.out_fail;
			out_last  <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid       = out_valid_q;
	assign stat.acc_nonpos = (acc_q <= 64'sd0);
	assign stat.div_done   = div_done;
	assign stat.sqrt_done  = sqrt_done;
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

// File: hw/rtl/cfe_ctrl.sv
// Controller: load counters, factorisation sequencer and emit sequencer.
module cfe_ctrl import cfe_pkg::*; #(
	parameter int MAX_N = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data,
	output cfe_cmd_t          cmd,
	input  cfe_stat_t         stat
);

	typedef enum logic [12:0] {
		S_LOAD   = 13'b0000000000001,
		S_AINIT  = 13'b0000000000010,
		S_ALOAD  = 13'b0000000000100,
		S_KRD    = 13'b0000000001000,
		S_KMUL   = 13'b0000000010000,
		S_KSUB   = 13'b0000000100000,
		S_FIN    = 13'b0000001000000,
		S_DSTART = 13'b0000010000000,
		S_DWAIT  = 13'b0000100000000,
		S_SQWAIT = 13'b0001000000000,
		S_ZERO   = 13'b0010000000000,
		S_NEXT   = 13'b0100000000000,
		S_EMIT   = 13'b1000000000000
	} state_t;

	// S_EMIT covers the read and output cycles with a phase bit
	state_t            state_q;
	logic              eph_q;
	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  row_q, col_q, i_q, j_q, k_q, n_last;
	logic              fail_q, in_acc, last_in, elem_last;

	always_comb begin
		if (size_q == '0)
			n_last = '0;
		else if (size_q > SIZE_W'(MAX_N))
			n_last = IDX_W'(MAX_N - 1);
		else
			n_last = IDX_W'(size_q - 4'd1);
	end

	// a size write takes precedence over a word offered in the same cycle
	assign in_ready  = (state_q == S_LOAD) && !cfg_valid;
	assign cfg_ready = (state_q == S_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign last_in   = (row_q == n_last) && (col_q == n_last);
	assign elem_last = (i_q == n_last) && (j_q == i_q);

	always_comb begin
		cmd          = '0;
		cmd.wr_src   = WSRC_ZERO;
		cmd.wr_row   = i_q;
		cmd.wr_col   = j_q;
		cmd.ra_row   = i_q;
		cmd.ra_col   = j_q;
		cmd.rb_row   = j_q;
		cmd.rb_col   = j_q;
		cmd.out_fail = fail_q;
		cmd.out_last = elem_last;
		unique case (state_q)
			S_LOAD: begin
				cmd.wr_src = WSRC_IN;
				cmd.wr_row = row_q;
				cmd.wr_col = col_q;
				cmd.wr_en  = in_acc && (col_q <= row_q);
			end
			S_AINIT:  cmd.rd_en = 1'b1;
			S_ALOAD:  cmd.acc_load = 1'b1;
			S_KRD: begin
				cmd.rd_en  = 1'b1;
				cmd.ra_col = k_q;
				cmd.rb_col = k_q;
			end
			S_KMUL:   cmd.mul_en = 1'b1;
			S_KSUB:   cmd.acc_sub = 1'b1;
			S_FIN: begin
				if (i_q != j_q)
					cmd.rd_en = 1'b1;
				else if (!stat.acc_nonpos)
					cmd.sqrt_start = 1'b1;
				else
					cmd.wr_en = 1'b1;
			end
			S_DSTART: cmd.div_start = 1'b1;
			S_DWAIT: begin
				cmd.wr_src = WSRC_DIV;
				cmd.wr_en  = stat.div_done;
			end
			S_SQWAIT: begin
				cmd.wr_src = WSRC_SQRT;
				cmd.wr_en  = stat.sqrt_done;
			end
			S_ZERO:   cmd.wr_en = 1'b1;
			S_NEXT:   cmd.rd_en = 1'b0;
			S_EMIT: begin
				cmd.rd_en    = !eph_q;
				cmd.out_load = eph_q && stat.out_free;
			end
			default:  cmd.rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			eph_q   <= 1'b0;
			size_q  <= SIZE_RESET;
			row_q   <= '0;
			col_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			fail_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
				row_q  <= '0;
				col_q  <= '0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (last_in) begin
							row_q   <= '0;
							col_q   <= '0;
							i_q     <= '0;
							j_q     <= '0;
							fail_q  <= 1'b0;
							state_q <= S_AINIT;
						end else if (col_q == n_last) begin
							col_q <= '0;
							row_q <= row_q + 3'd1;
						end else begin
							col_q <= col_q + 3'd1;
						end
					end
				end
				S_AINIT:  state_q <= S_ALOAD;
				S_ALOAD: begin
					k_q     <= '0;
					state_q <= (j_q == '0) ? S_FIN : S_KRD;
				end
				S_KRD:    state_q <= S_KMUL;
				S_KMUL:   state_q <= S_KSUB;
				S_KSUB: begin
					k_q     <= k_q + 3'd1;
					state_q <= (k_q + 3'd1 == j_q) ? S_FIN : S_KRD;
				end
				S_FIN: begin
					if (i_q != j_q) begin
						state_q <= S_DSTART;
					end else if (!stat.acc_nonpos) begin
						state_q <= S_SQWAIT;
					end else begin
						fail_q  <= 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT:  if (stat.div_done) state_q <= S_NEXT;
				S_SQWAIT: if (stat.sqrt_done) state_q <= S_NEXT;
				S_ZERO:   state_q <= S_NEXT;
				S_NEXT: begin
					if (elem_last) begin
						i_q     <= '0;
						j_q     <= '0;
						eph_q   <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						if (j_q == i_q) begin
							i_q <= i_q + 3'd1;
							j_q <= '0;
						end else begin
							j_q <= j_q + 3'd1;
						end
						state_q <= fail_q ? S_ZERO : S_AINIT;
					end
				end
				S_EMIT: begin
					if (!eph_q) begin
						eph_q <= 1'b1;
					end else if (stat.out_free) begin
						eph_q <= 1'b0;
						if (elem_last) begin
							state_q <= S_LOAD;
						end else if (j_q == i_q) begin
							i_q <= i_q + 3'd1;
							j_q <= '0;
						end else begin
							j_q <= j_q + 3'd1;
						end
					end
				end
				default:  state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// File: hw/rtl/cholesky_factorization_engine.sv
// Load: one word per cycle while no size write is offered; the factorisation starts on the
// last element of the n x n matrix. Per factor element: store read and accumulator load, then
// read, multiply and subtract per inner product term, then the serial divider (off-diagonal)
// or the serial root unit (diagonal). Emit: one registered store read per factor word, then
// the output load once the output register is free. Reset clears the controller, size (8) and
// output valid; the store is undefined until loaded and needs no clearing pass.
module cholesky_factorization_engine import cfe_pkg::*; #(
	parameter int MAX_N     = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// input stream: [31:0] element_value
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [DATA_W-1:0]   s_tdata,
	// output stream: [31:0] factor_value, [34:32] row_index, [37:35] col_index, zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_TD_W-1:0] m_tdata,
	// [0] not_positive
	output logic                m_tuser,
	output logic                m_tlast,
	// size_in_use register write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SIZE_W-1:0]   cfg_data
);

	cfe_cmd_t          cmd;
	cfe_stat_t         stat;
	logic [DATA_W-1:0] out_value;
	logic [IDX_W-1:0]  out_row, out_col;

	// sequencing: load counters, per-element compute walk, emit walk
	cfe_ctrl #(.MAX_N(MAX_N)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.cmd(cmd), .stat(stat)
	);

	// store, MAC, divider, root and the output register (m_tready reaches the controller combinationally)
	cfe_dpath #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_data(s_tdata),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_value(out_value), .out_row(out_row), .out_col(out_col),
		.out_fail(m_tuser), .out_last(m_tlast)
	);

	assign m_tdata = {2'b00, out_col, out_row, out_value};

endmodule
